@@ rtl/afsk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afsk_pkg
// Item codes, register indexes, reset values and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package afsk_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_TONE_TICKS    = 3'd0;
  localparam logic [2:0] CFG_SILENCE_TICKS = 3'd1;
  localparam logic [2:0] CFG_PACKET_BITS   = 3'd2;
  localparam logic [2:0] CFG_BIT_PERIOD    = 3'd3;
  localparam logic [2:0] CFG_MARK_STRIDE   = 3'd4;
  localparam logic [2:0] CFG_SPACE_STRIDE  = 3'd5;
  localparam logic [2:0] CFG_TONE_STRIDE   = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Register reset values
  localparam logic [19:0] BIT_PERIOD_RESET   = 20'd104167;
  localparam logic [15:0] MARK_STRIDE_RESET  = 16'd315;
  localparam logic [15:0] SPACE_STRIDE_RESET = 16'd577;
  localparam logic [15:0] TONE_STRIDE_RESET  = 16'd79;

  localparam logic [11:0] MIDSCALE     = 12'd2047;
  localparam logic [12:0] MIRROR_BASE  = 13'd4097;
  localparam logic [7:0]  QW_LAST      = 8'd128;

  // Quarter wave, 129 points from midscale up to full scale
  localparam logic [11:0] QUARTER_WAVE [0:128] = '{
    12'd2047, 12'd2072, 12'd2097, 12'd2122, 12'd2147, 12'd2173, 12'd2198, 12'd2223,
    12'd2248, 12'd2273, 12'd2298, 12'd2323, 12'd2348, 12'd2372, 12'd2397, 12'd2422,
    12'd2447, 12'd2471, 12'd2496, 12'd2520, 12'd2545, 12'd2569, 12'd2593, 12'd2617,
    12'd2642, 12'd2666, 12'd2689, 12'd2713, 12'd2737, 12'd2761, 12'd2784, 12'd2807,
    12'd2831, 12'd2854, 12'd2877, 12'd2900, 12'd2923, 12'd2945, 12'd2968, 12'd2990,
    12'd3012, 12'd3035, 12'd3056, 12'd3078, 12'd3100, 12'd3121, 12'd3143, 12'd3164,
    12'd3185, 12'd3206, 12'd3226, 12'd3247, 12'd3267, 12'd3287, 12'd3307, 12'd3327,
    12'd3346, 12'd3366, 12'd3385, 12'd3404, 12'd3422, 12'd3441, 12'd3459, 12'd3477,
    12'd3495, 12'd3513, 12'd3530, 12'd3547, 12'd3564, 12'd3581, 12'd3598, 12'd3614,
    12'd3630, 12'd3646, 12'd3662, 12'd3677, 12'd3692, 12'd3707, 12'd3721, 12'd3736,
    12'd3750, 12'd3764, 12'd3777, 12'd3791, 12'd3804, 12'd3816, 12'd3829, 12'd3841,
    12'd3853, 12'd3865, 12'd3876, 12'd3887, 12'd3898, 12'd3909, 12'd3919, 12'd3929,
    12'd3939, 12'd3949, 12'd3958, 12'd3967, 12'd3975, 12'd3984, 12'd3992, 12'd3999,
    12'd4007, 12'd4014, 12'd4021, 12'd4027, 12'd4034, 12'd4040, 12'd4045, 12'd4051,
    12'd4056, 12'd4060, 12'd4065, 12'd4069, 12'd4073, 12'd4076, 12'd4080, 12'd4083,
    12'd4085, 12'd4087, 12'd4089, 12'd4091, 12'd4093, 12'd4094, 12'd4094, 12'd4095,
    12'd4095
  };

endpackage

@@ rtl/afsk_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afsk_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface afsk_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_index;
  logic [7:0] byte_value;

  modport source (output valid, output kind, output byte_index, output byte_value,
                  input ready);
  modport sink   (input valid, input kind, input byte_index, input byte_value,
                  output ready);
endinterface

interface afsk_result_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample;
  logic        busy_res;
  logic        done_res;

  modport source (output valid, output sample, output busy_res, output done_res,
                  input ready);
  modport sink   (input valid, input sample, input busy_res, input done_res,
                  output ready);
endinterface

@@ rtl/afsk_wave.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afsk_wave
// Phase to DAC sample: mirror the quarter-wave table into a full period.
// ----------------------------------------------------------------------------
module afsk_wave #(
  parameter int WAVE_POINTS     = 512,
  parameter int PHASE_FRAC_BITS = 6
) (
  input  logic [15:0] phase,
  output logic [11:0] sample
);

  localparam int PW = $clog2(WAVE_POINTS);
  localparam int QB = PW - 2;

  logic [PW+15:0] phase_sh;
  logic [PW-1:0]  point;
  logic [1:0]     quadrant;
  logic [QB-1:0]  offset;
  logic [QB:0]    q;
  logic [QB+7:0]  scaled;
  logic [QB+7:0]  idx_w;
  logic [7:0]     idx;
  logic [11:0]    table_val;

  always_comb begin
    phase_sh = {{PW{1'b0}}, phase} >> PHASE_FRAC_BITS;
    point    = phase_sh[PW-1:0];
    quadrant = point[PW-1:PW-2];
    offset   = point[QB-1:0];
    // Odd quadrants index the table down from its peak
    if (quadrant[0]) begin
      q = (QB+1)'(1 << QB) - {1'b0, offset};
    end else begin
      q = {1'b0, offset};
    end
    scaled = (QB+8)'(q) << 7;
    idx_w  = scaled >> QB;
    if (idx_w > (QB+8)'(afsk_pkg::QW_LAST)) begin
      idx = afsk_pkg::QW_LAST;
    end else begin
      idx = idx_w[7:0];
    end
    table_val = afsk_pkg::QUARTER_WAVE[idx];
    if (quadrant[1]) begin
      sample = 12'(afsk_pkg::MIRROR_BASE - {1'b0, table_val});
    end else begin
      sample = table_val;
    end
  end

endmodule

@@ rtl/afsk_nrzi_dds_modulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afsk_nrzi_dds_modulator
// AFSK packet modulator: NRZI bit coding, DDS tone source, 12-bit DAC samples.
// ----------------------------------------------------------------------------
// Usage:
//   item channel carries three kinds: a packet byte write (byte_index,
//   byte_value), a start, and a sample tick. Only a tick returns a result on
//   the result channel: sample, busy_res (still sending after this tick) and
//   done_res (this tick ended the transmission).
//   A transmission plays tone_ticks of pre-tone, silence_ticks of held
//   output, then packet_bits bits LSB first; a zero bit swaps mark and space.
//   Configuration is written on cfg_we/cfg_index/cfg_data while idle.
// Latency and throughput:
//   One item per cycle, every kind, while item ready is high. A tick's result
//   is registered and is offered on the cycle after the transfer. The
//   packet byte for the next bit is read from a synchronous store at the
//   address that the next bit position selects, with a bypass for a byte
//   written in the same cycle, so data bits never wait on the store.
// Reset:
//   Idle, phase and counters zero, registers at their defaults. The packet
//   store is not cleared and must be written before it is sent.
// Stall:
//   While a result waits and the receiver holds ready low, item ready drops;
//   a waiting result is taken and a new item accepted in the same cycle.
//   BUFFER_BYTES and WAVE_POINTS must be powers of two.
// ----------------------------------------------------------------------------
module afsk_nrzi_dds_modulator #(
  parameter int BUFFER_BYTES    = 256,
  parameter int PHASE_FRAC_BITS = 6,
  parameter int WAVE_POINTS     = 512,
  parameter int TIMER_SCALE     = 1000
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [afsk_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [afsk_pkg::CFG_DATA_W-1:0]   cfg_data,
  afsk_item_if.sink                         item,
  afsk_result_if.source                     result
);

  localparam int ABITS = $clog2(BUFFER_BYTES);
  localparam int WI_W  = ((ABITS > 8) ? ABITS : 8) + 1;
  localparam int BA_W  = (ABITS > 9) ? ABITS : 9;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_TONE    = 2'd1;
  localparam logic [1:0] MODE_SILENCE = 2'd2;
  localparam logic [1:0] MODE_DATA    = 2'd3;

  localparam logic [20:0] TS21 = 21'(TIMER_SCALE);

  // Configuration registers
  logic [23:0] tone_ticks;
  logic [23:0] silence_ticks;
  logic [11:0] packet_bits;
  logic [19:0] bit_period_scaled;
  logic [15:0] mark_stride;
  logic [15:0] space_stride;
  logic [15:0] tone_stride;

  // Transmission state
  logic [1:0]  mode, mode_next;
  logic [15:0] phase, phase_next;
  logic [15:0] stride, stride_next;
  logic [11:0] bit_pos, bit_pos_next;
  logic [20:0] bit_timer, bit_timer_next;
  logic [7:0]  shift, shift_next;
  logic [23:0] ticks_left, ticks_left_next;

  // Packet store
  logic [7:0]       store [BUFFER_BYTES];
  logic [7:0]       rd_data;
  logic [WI_W-1:0]  wix;
  logic [ABITS-1:0] waddr;
  logic             wen;
  logic [BA_W-1:0]  rwide;
  logic [ABITS-1:0] raddr;

  // Output register
  logic        ovalid;
  logic [11:0] osample;
  logic        obusy;
  logic        odone;

  logic        acc;
  logic        use_wave;
  logic        done_next;
  logic [11:0] wave_sample;
  logic [20:0] period_eff;
  logic [21:0] bt;
  logic [23:0] ticks_dec;
  logic [15:0] stride_tmp;
  logic [7:0]  sb;

  assign item.ready = !ovalid || result.ready;
  assign acc        = item.valid && item.ready;

  assign result.valid    = ovalid;
  assign result.sample   = osample;
  assign result.busy_res = obusy;
  assign result.done_res = odone;

  // Configuration writes; index seven is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_ticks        <= '0;
      silence_ticks     <= '0;
      packet_bits       <= '0;
      bit_period_scaled <= afsk_pkg::BIT_PERIOD_RESET;
      mark_stride       <= afsk_pkg::MARK_STRIDE_RESET;
      space_stride      <= afsk_pkg::SPACE_STRIDE_RESET;
      tone_stride       <= afsk_pkg::TONE_STRIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        afsk_pkg::CFG_TONE_TICKS:    tone_ticks        <= cfg_data;
        afsk_pkg::CFG_SILENCE_TICKS: silence_ticks     <= cfg_data;
        afsk_pkg::CFG_PACKET_BITS:   packet_bits       <= cfg_data[11:0];
        afsk_pkg::CFG_BIT_PERIOD:    bit_period_scaled <= cfg_data[19:0];
        afsk_pkg::CFG_MARK_STRIDE:   mark_stride       <= cfg_data[15:0];
        afsk_pkg::CFG_SPACE_STRIDE:  space_stride      <= cfg_data[15:0];
        afsk_pkg::CFG_TONE_STRIDE:   tone_stride       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Byte writes beyond the store are dropped
  assign wix   = WI_W'(item.byte_index);
  assign waddr = wix[ABITS-1:0];
  assign wen   = acc && (item.kind == afsk_pkg::KIND_WRITE) &&
                 (wix < WI_W'(BUFFER_BYTES));

  // Read the byte that the next bit position points at, wrapping the address
  assign rwide = BA_W'(bit_pos_next[11:3]);
  assign raddr = rwide[ABITS-1:0];

  always_ff @(posedge clk) begin
    if (wen) begin
      store[waddr] <= item.byte_value;
    end
    // Forward a byte written to the address being read
    if (wen && (waddr == raddr)) begin
      rd_data <= item.byte_value;
    end else begin
      rd_data <= store[raddr];
    end
  end

  // Next-state logic for one accepted item
  always_comb begin
    mode_next       = mode;
    phase_next      = phase;
    stride_next     = stride;
    bit_pos_next    = bit_pos;
    bit_timer_next  = bit_timer;
    shift_next      = shift;
    ticks_left_next = ticks_left;
    use_wave        = 1'b0;
    done_next       = 1'b0;
    period_eff      = ({1'b0, bit_period_scaled} < TS21) ? TS21 : {1'b0, bit_period_scaled};
    ticks_dec       = ticks_left - 24'd1;
    stride_tmp      = stride;
    sb              = shift;
    bt              = {1'b0, bit_timer} + {1'b0, TS21};
    if (acc) begin
      case (item.kind)
        afsk_pkg::KIND_START: begin
          phase_next     = '0;
          bit_pos_next   = '0;
          bit_timer_next = '0;
          if (tone_ticks == 24'd0) begin
            mode_next       = MODE_DATA;
            stride_next     = mark_stride;
            ticks_left_next = '0;
          end else begin
            mode_next       = MODE_TONE;
            stride_next     = tone_stride;
            ticks_left_next = tone_ticks;
          end
        end
        afsk_pkg::KIND_TICK: begin
          case (mode)
            MODE_IDLE: ;
            MODE_TONE: begin
              phase_next = phase + stride;
              use_wave   = 1'b1;
              if (ticks_dec == 24'd0) begin
                mode_next       = MODE_SILENCE;
                ticks_left_next = silence_ticks;
              end else begin
                ticks_left_next = ticks_dec;
              end
            end
            MODE_SILENCE: begin
              use_wave = 1'b1;
              if (ticks_left == 24'd0) begin
                // Restart from zero phase on the mark tone
                mode_next   = MODE_DATA;
                stride_next = mark_stride;
                phase_next  = mark_stride;
              end else begin
                ticks_left_next = ticks_dec;
              end
            end
            default: begin
              if (bit_pos == packet_bits) begin
                mode_next = MODE_IDLE;
                done_next = 1'b1;
              end else begin
                // First tick of a bit: fetch it and apply NRZI
                if (bit_timer < TS21) begin
                  if (bit_pos[2:0] == 3'd0) begin
                    sb = rd_data;
                  end else begin
                    sb = shift >> 1;
                  end
                  if (!sb[0]) begin
                    stride_tmp = stride ^ (mark_stride ^ space_stride);
                  end
                end
                if (bt >= {1'b0, period_eff}) begin
                  bt           = bt - {1'b0, period_eff};
                  bit_pos_next = bit_pos + 12'd1;
                end
                bit_timer_next = bt[20:0];
                shift_next     = sb;
                stride_next    = stride_tmp;
                phase_next     = phase + stride_tmp;
                use_wave       = 1'b1;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  afsk_wave #(
    .WAVE_POINTS     (WAVE_POINTS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_wave (
    .phase  (phase_next),
    .sample (wave_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      phase      <= '0;
      stride     <= '0;
      bit_pos    <= '0;
      bit_timer  <= '0;
      shift      <= '0;
      ticks_left <= '0;
    end else begin
      mode       <= mode_next;
      phase      <= phase_next;
      stride     <= stride_next;
      bit_pos    <= bit_pos_next;
      bit_timer  <= bit_timer_next;
      shift      <= shift_next;
      ticks_left <= ticks_left_next;
    end
  end

  // Result register: load on a tick transfer, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (acc && (item.kind == afsk_pkg::KIND_TICK)) begin
      ovalid <= 1'b1;
    end else if (result.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (item.kind == afsk_pkg::KIND_TICK)) begin
      osample <= use_wave ? wave_sample : afsk_pkg::MIDSCALE;
      obusy   <= (mode_next != MODE_IDLE);
      odone   <= done_next;
    end
  end

  // A start always leaves the block in tone or data
  a_start_mode: assert property (@(posedge clk) disable iff (rst)
    (acc && (item.kind == afsk_pkg::KIND_START)) |=>
      ((mode == MODE_TONE) || (mode == MODE_DATA)))
    else $error("start did not enter tone or data");

  // The tone never sits with no ticks left
  a_tone_count: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_TONE) |-> (ticks_left != 24'd0))
    else $error("tone with zero ticks left");

  // A new result appears only after a tick transfer
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (ovalid && !$past(ovalid)) |-> $past(acc && (item.kind == afsk_pkg::KIND_TICK)))
    else $error("result without a tick");

  // The end of a transmission reports not busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (ovalid && odone) |-> !obusy)
    else $error("done while busy");

endmodule
